FILE: design/streebog512_hash_top_assert.svh
// assertion macros for the hash engine
`ifndef STREEBOG512_HASH_TOP_ASSERT_SVH
`define STREEBOG512_HASH_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SB_ASSERT(lbl, prop, msg)
`define SB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: design/sb512_pkg.sv
package sb512_pkg;

	localparam int unsigned ROUNDS = 12;
	localparam logic [3:0] LAST_ROUND = 4'(ROUNDS - 1);
	localparam logic [3:0] MAX_BYTES = 4'd8;
	localparam logic [9:0] BLOCK_BITS = 10'd512;
	localparam logic [7:0] PAD_BYTE = 8'h01;
	localparam logic [2:0] LAST_WORD_IDX = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ABSORB,
		ST_PAD,
		ST_INIT,
		ST_STATE,
		ST_KEY,
		ST_POST,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_BLOCK,
		PH_TAIL,
		PH_CNT,
		PH_SUM
	} phase_t;

	localparam logic [7:0] PI_SBOX [256] = '{
		8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
		8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
		8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
		8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
		8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
		8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
		8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
		8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
		8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
		8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
		8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
		8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
		8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
		8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
		8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
		8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6
	};

	localparam logic [63:0] LIN_MATRIX [64] = '{
		64'h8e20faa72ba0b470,64'h47107ddd9b505a38,64'had08b0e0c3282d1c,64'hd8045870ef14980e,
		64'h6c022c38f90a4c07,64'h3601161cf205268d,64'h1b8e0b0e798c13c8,64'h83478b07b2468764,
		64'ha011d380818e8f40,64'h5086e740ce47c920,64'h2843fd2067adea10,64'h14aff010bdd87508,
		64'h0ad97808d06cb404,64'h05e23c0468365a02,64'h8c711e02341b2d01,64'h46b60f011a83988e,
		64'h90dab52a387ae76f,64'h486dd4151c3dfdb9,64'h24b86a840e90f0d2,64'h125c354207487869,
		64'h092e94218d243cba,64'h8a174a9ec8121e5d,64'h4585254f64090fa0,64'haccc9ca9328a8950,
		64'h9d4df05d5f661451,64'hc0a878a0a1330aa6,64'h60543c50de970553,64'h302a1e286fc58ca7,
		64'h18150f14b9ec46dd,64'h0c84890ad27623e0,64'h0642ca05693b9f70,64'h0321658cba93c138,
		64'h86275df09ce8aaa8,64'h439da0784e745554,64'hafc0503c273aa42a,64'hd960281e9d1d5215,
		64'he230140fc0802984,64'h71180a8960409a42,64'hb60c05ca30204d21,64'h5b068c651810a89e,
		64'h456c34887a3805b9,64'hac361a443d1c8cd2,64'h561b0d22900e4669,64'h2b838811480723ba,
		64'h9bcf4486248d9f5d,64'hc3e9224312c8c1a0,64'heffa11af0964ee50,64'hf97d86d98a327728,
		64'he4fa2054a80b329c,64'h727d102a548b194e,64'h39b008152acb8227,64'h9258048415eb419d,
		64'h492c024284fbaec0,64'haa16012142f35760,64'h550b8e9e21f7a530,64'ha48b474f9ef5dc18,
		64'h70a6a56e2440598e,64'h3853dc371220a247,64'h1ca76e95091051ad,64'h0edd37c48a08a6d8,
		64'h07e095624504536c,64'h8d70c431ac02a736,64'hc83862965601dd1b,64'h641c314b2b8ee083
	};

	// round constants, word 0 least significant
	localparam logic [63:0] ROUND_CONST [12][8] = '{
		'{64'hdd806559f2a64507,64'h05767436cc744d23,64'ha2422a08a460d315,64'h4b7ce09192676901,
		  64'h714eb88d7585c4fc,64'h2f6a76432e45d016,64'hebcb2f81c0657c1f,64'hb1085bda1ecadae9},
		'{64'he679047021b19bb7,64'h55dda21bd7cbcd56,64'h5cb561c2db0aa7ca,64'h9ab5176b12d69958,
		  64'h61d55e0f16b50131,64'hf3feea720a232b98,64'h4fe39d460f70b5d7,64'h6fa3b58aa99d2f1a},
		'{64'h991e96f50aba0ab2,64'hc2b6f443867adb31,64'hc1c93a376062db09,64'hd3e20fe490359eb1,
		  64'hf2ea7514b1297b7b,64'h06f15e5f529c1f8b,64'h0a39fc286a3d8435,64'hf574dcac2bce2fc7},
		'{64'h220cbebc84e3d12e,64'h3453eaa193e837f1,64'hd8b71333935203be,64'ha9d72c82ed03d675,
		  64'h9d721cad685e353f,64'h488e857e335c3c7d,64'hf948e1a05d71e4dd,64'hef1fdfb3e81566d2},
		'{64'h601758fd7c6cfe57,64'h7a56a27ea9ea63f5,64'hdfff00b723271a16,64'hbfcd1747253af5a3,
		  64'h359e35d7800fffbd,64'h7f151c1f1686104a,64'h9a3f410c6ca92363,64'h4bea6bacad474799},
		'{64'hfa68407a46647d6e,64'hbf71c57236904f35,64'h0af21f66c2bec6b6,64'hcffaa6b71c9ab7b4,
		  64'h187f9ab49af08ec6,64'h2d66c4f95142a46c,64'h6fa4c33b7a3039c0,64'hae4faeae1d3ad3d9},
		'{64'h8886564d3a14d493,64'h3517454ca23c4af3,64'h06476983284a0504,64'h0992abc52d822c37,
		  64'hd3473e33197a93c9,64'h399ec6c7e6bf87c9,64'h51ac86febf240954,64'hf4c70e16eeaac5ec},
		'{64'ha47f0dd4bf02e71e,64'h36acc2355951a8d9,64'h69d18d2bd1a5c42f,64'hf4892bcb929b0690,
		  64'h89b4443b4ddbc49a,64'h4eb7f8719c36de1e,64'h03e7aa020c6e4141,64'h9b1f5b424d93c9a7},
		'{64'h7261445183235adb,64'h0e38dc92cb1f2a60,64'h7b2b8a9aa6079c54,64'h800a440bdbb2ceb1,
		  64'h3cd955b7e00d0984,64'h3a7d3a1b25894224,64'h944c9ad8ec165fde,64'h378f5a541631229b},
		'{64'h74b4c7fb98459ced,64'h3698fad1153bb6c3,64'h7a1e6c303b7652f4,64'h9fe76702af69334b,
		  64'h1fffe18a1b336103,64'h8941e71cff8a78db,64'h382ae548b2e4f3f3,64'habbedea680056f52},
		'{64'h6bcaa4cd81f32d1b,64'hdea2594ac06fd85d,64'hefbacd1d7d476e98,64'h8a1d71efea48b9ca,
		  64'h2001802114846679,64'hd8fa6bbbebab0761,64'h3002c6cd635afe94,64'h7bcd9ed0efc889fb},
		'{64'h48bc924af11bd720,64'hfaf417d5d9b21b99,64'he71da4aa88e12852,64'h5d80ef9d1891cc86,
		  64'hf82012d430219f9b,64'hcda43c32bcdf1d77,64'hd21380b00449b17a,64'h378ee767f11631ba}
	};

	// round constant r as one 512-bit vector
	function automatic logic [511:0] round_const(input logic [3:0] r);
		logic [511:0] v;
		v = '0;
		for (int i = 0; i < 8; i++) begin
			v[64*i +: 64] = ROUND_CONST[r][i];
		end
		return v;
	endfunction

	// linear map L on one 64-bit row
	function automatic logic [63:0] lin_map(input logic [63:0] w);
		logic [63:0] o;
		o = '0;
		for (int j = 0; j < 64; j++) begin
			if (w[j]) begin
				o = o ^ LIN_MATRIX[63-j];
			end
		end
		return o;
	endfunction

endpackage

FILE: design/sb512_lps.sv
module sb512_lps import sb512_pkg::*; (
	input  logic [511:0] din,
	output logic [511:0] dout
);

	// s-box, byte transposition and linear map, one row per output word
	always_comb begin
		logic [63:0] w;
		w = '0;
		dout = '0;
		for (int r = 0; r < 8; r++) begin
			for (int c = 0; c < 8; c++) begin
				w[8*c +: 8] = PI_SBOX[din[64*c + 8*r +: 8]];
			end
			dout[64*r +: 64] = lin_map(w);
		end
	end

endmodule

FILE: design/streebog512_hash_top.sv
// Streebog-512 hash engine. Message bytes arrive up to eight per beat, first byte in the
// low bits; a beat with final_req set closes the message and the 512-bit digest leaves as
// eight beats, least significant word first, last_word on the eighth. An ordinary beat
// is accepted, then written into the block buffer. A beat that completes a 64-byte block
// adds a compression: a key setup step, 12 rounds each of a state step and a key step, a
// step that updates the length counter and checksum, and one more buffer write for the
// bytes left over. The rate is set by the single LPS unit, which the key schedule and the
// data state take in turns. The final beat adds a padding step and three compressions
// before the eight digest beats; after the last beat the engine is back in idle with the
// chaining value, length counter, checksum and fill cleared for a new message.
`include "streebog512_hash_top_assert.svh"

module streebog512_hash_top import sb512_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	output logic        msg_ready,
	input  logic [63:0] message_word,
	input  logic [3:0]  byte_count,
	input  logic        final_req,
	output logic        digest_valid,
	input  logic        digest_ready,
	output logic [63:0] digest_word,
	output logic        last_word
);

	state_t state_q, state_d;
	phase_t phase_q;
	logic [3:0]   round_q;
	logic [2:0]   out_idx_q;
	logic [5:0]   fill_q;
	logic [63:0]  word_q;
	logic [3:0]   cnt_q;
	logic         fin_q;
	logic [8:0]   tail_bits_q;
	logic [511:0] chain_q, count_q, sum_q, key_q, st_q;
	logic [511:0] buf_q;

	logic [511:0] lps_in, lps_out, m_sel;
	logic [6:0]   space;
	logic [3:0]   n_fit;
	logic         blk_full;
	logic         last_round;
	logic [9:0]   inc;

	sb512_lps u_lps (
		.din  (lps_in),
		.dout (lps_out)
	);

	// buffer fill arithmetic
	assign space    = 7'd64 - {1'b0, fill_q};
	assign blk_full = {3'b0, cnt_q} >= space;
	assign n_fit    = blk_full ? space[3:0] : cnt_q;
	assign last_round = round_q == LAST_ROUND;
	assign inc = (phase_q == PH_BLOCK) ? BLOCK_BITS : {1'b0, tail_bits_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (msg_valid) state_d = ST_ABSORB;
			end
			ST_ABSORB: begin
				if (blk_full) state_d = ST_INIT;
				else if (fin_q) state_d = ST_PAD;
				else state_d = ST_IDLE;
			end
			ST_PAD:   state_d = ST_INIT;
			ST_INIT:  state_d = ST_STATE;
			ST_STATE: state_d = ST_KEY;
			ST_KEY: begin
				if (!last_round) state_d = ST_STATE;
				else if (phase_q == PH_BLOCK || phase_q == PH_TAIL) state_d = ST_POST;
				else if (phase_q == PH_CNT) state_d = ST_INIT;
				else state_d = ST_OUT;
			end
			ST_POST: begin
				state_d = (phase_q == PH_BLOCK) ? ST_ABSORB : ST_INIT;
			end
			ST_OUT: begin
				if (digest_ready && out_idx_q == LAST_WORD_IDX) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and lps operand select
	always_comb begin
		msg_ready    = state_q == ST_IDLE;
		digest_valid = state_q == ST_OUT;
		digest_word  = chain_q[64*out_idx_q +: 64];
		last_word    = out_idx_q == LAST_WORD_IDX;
		unique case (phase_q)
			PH_BLOCK, PH_TAIL: m_sel = buf_q;
			PH_CNT:            m_sel = count_q;
			PH_SUM:            m_sel = sum_q;
			default:           m_sel = buf_q;
		endcase
		unique case (state_q)
			ST_INIT: begin
				lps_in = (phase_q == PH_BLOCK || phase_q == PH_TAIL) ?
					(chain_q ^ count_q) : chain_q;
			end
			ST_STATE: lps_in = st_q;
			ST_KEY:   lps_in = key_q ^ round_const(round_q);
			default:  lps_in = st_q;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= PH_BLOCK;
			round_q   <= '0;
			out_idx_q <= '0;
			fill_q    <= '0;
			cnt_q     <= '0;
			fin_q     <= 1'b0;
			chain_q   <= '0;
			count_q   <= '0;
			sum_q     <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (msg_valid) begin
						cnt_q <= (byte_count > MAX_BYTES) ? MAX_BYTES : byte_count;
						fin_q <= final_req;
					end
				end
				ST_ABSORB: begin
					if (blk_full) begin
						fill_q  <= '0;
						cnt_q   <= cnt_q - n_fit;
						phase_q <= PH_BLOCK;
					end else begin
						fill_q <= fill_q + 6'(cnt_q);
						cnt_q  <= '0;
					end
				end
				ST_PAD:  phase_q <= PH_TAIL;
				ST_INIT: round_q <= '0;
				ST_KEY: begin
					if (last_round) begin
						chain_q <= chain_q ^ st_q ^ lps_out ^ m_sel;
						if (phase_q == PH_CNT) phase_q <= PH_SUM;
					end else begin
						round_q <= round_q + 4'd1;
					end
				end
				ST_POST: begin
					count_q <= count_q + 512'(inc);
					sum_q   <= sum_q + buf_q;
					if (phase_q == PH_TAIL) phase_q <= PH_CNT;
				end
				ST_OUT: begin
					if (digest_ready) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (out_idx_q == LAST_WORD_IDX) begin
							chain_q <= '0;
							count_q <= '0;
							sum_q   <= '0;
							fill_q  <= '0;
							phase_q <= PH_BLOCK;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (msg_valid) word_q <= message_word;
			end
			ST_ABSORB: begin
				for (int p = 0; p < 64; p++) begin
					logic [6:0] off;
					off = 7'(p) - {1'b0, fill_q};
					if (7'(p) >= {1'b0, fill_q} && off < {3'b0, n_fit}) begin
						buf_q[8*p +: 8] <= word_q[8*off[2:0] +: 8];
					end
				end
				word_q <= word_q >> {n_fit, 3'b0};
			end
			ST_PAD: begin
				for (int p = 0; p < 64; p++) begin
					if (6'(p) == fill_q) buf_q[8*p +: 8] <= PAD_BYTE;
					else if (6'(p) > fill_q) buf_q[8*p +: 8] <= '0;
				end
				tail_bits_q <= {fill_q, 3'b0};
			end
			ST_INIT: begin
				key_q <= lps_out;
				st_q  <= m_sel ^ lps_out;
			end
			ST_STATE: st_q <= lps_out;
			ST_KEY: begin
				key_q <= lps_out;
				st_q  <= st_q ^ lps_out;
			end
			default: ;
		endcase
	end

	`SB_ASSERT(a_no_overlap, !(msg_ready && digest_valid), "accepting while digest pending")
	`SB_ASSERT(a_accept_absorb, (msg_valid && msg_ready) |=> (state_q == ST_ABSORB),
		"accepted beat not absorbed")
	`SB_ASSERT(a_init_round, (state_q == ST_INIT) |=> (state_q == ST_STATE && round_q == 4'd0),
		"compression did not start at round zero")
	`SB_ASSERT(a_restart, (digest_valid && digest_ready && last_word) |=>
		(msg_ready && fill_q == 6'd0 && count_q == '0), "state not cleared after digest")

endmodule
